[src/assert_macros.svh]
// assertion macros shared by the queue and back end of the gaussian noise generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds in the cycle after trig
`define ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("assertion failed");

// expr never holds
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("assertion failed");

`endif

[src/gng_pkg.sv]
// shared constants, types and tables of the gaussian noise generator
package gng_pkg;

	localparam int UNIFORM_BITS  = 24;
	localparam int FRACTION_BITS = 12;
	localparam int CORDIC_STEPS  = 28;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [31:0] SEED_DEFAULT   = 32'h12345678;
	localparam logic [28:0] TWO_LN2_Q28    = 29'd372130559;
	localparam logic [35:0] ZERO_U1_R2_Q30 = 36'd59337166024;
	localparam logic [29:0] INV_GAIN_Q30   = 30'd652032874;

	// pair of uniforms taken from two generator words
	typedef struct packed {
		logic [UNIFORM_BITS-1:0] m;
		logic [UNIFORM_BITS-1:0] v;
	} uni_pair_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// arctangent of 2^-i in turns, 2^32 per turn
	function automatic logic [29:0] turn_atan(input logic [4:0] i);
		logic [29:0] a;
		case (i)
			5'd0:  a = 30'h20000000;
			5'd1:  a = 30'h12e4051d;
			5'd2:  a = 30'h09fb385b;
			5'd3:  a = 30'h051111d4;
			5'd4:  a = 30'h028b0d43;
			5'd5:  a = 30'h0145d7e1;
			5'd6:  a = 30'h00a2f61e;
			5'd7:  a = 30'h00517c55;
			5'd8:  a = 30'h0028be53;
			5'd9:  a = 30'h00145f2e;
			5'd10: a = 30'h000a2f98;
			5'd11: a = 30'h000517cc;
			5'd12: a = 30'h00028be6;
			5'd13: a = 30'h000145f3;
			5'd14: a = 30'h0000a2f9;
			5'd15: a = 30'h0000517c;
			5'd16: a = 30'h000028be;
			5'd17: a = 30'h0000145f;
			5'd18: a = 30'h00000a2f;
			5'd19: a = 30'h00000517;
			5'd20: a = 30'h0000028b;
			5'd21: a = 30'h00000145;
			5'd22: a = 30'h000000a2;
			5'd23: a = 30'h00000051;
			5'd24: a = 30'h00000028;
			5'd25: a = 30'h00000014;
			5'd26: a = 30'h0000000a;
			5'd27: a = 30'h00000005;
			default: a = 30'h0;
		endcase
		return a;
	endfunction

endpackage

[src/gng_front.sv]
// front end: draw acceptance and xorshift generator
module gng_front import gng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed_data,
	input  logic        draw_valid,
	output logic        draw_stall,
	input  logic        draw,
	input  q_status_t   q_status,
	output logic        push,
	output uni_pair_t   push_pair
);

	logic [31:0] gen_q;
	logic [31:0] w1, w2;

	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] a, b;
		a = x ^ (x << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

	assign w1         = xorshift(gen_q);
	assign w2         = xorshift(w1);
	assign draw_stall = q_status.full;
	assign push       = draw_valid && !q_status.full && draw;
	assign push_pair  = '{m: w1[UNIFORM_BITS-1:0], v: w2[UNIFORM_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= SEED_DEFAULT;
		end else if (seed_we) begin
			gen_q <= (seed_data != 32'd0) ? seed_data : SEED_DEFAULT;
		end else if (push) begin
			gen_q <= w2;
		end
	end

endmodule

[src/gng_queue.sv]
// short queue of uniform pairs between front and back
module gng_queue import gng_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  uni_pair_t push_pair,
	input  logic      pop,
	output uni_pair_t head,
	output q_status_t status
);

	`include "assert_macros.svh"

	localparam int PtrW = $clog2(QUEUE_DEPTH);

	uni_pair_t           entry_q [QUEUE_DEPTH];
	logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PtrW:0]       count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == (PtrW+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(q_no_overflow, push && status.full)
	`ASSERT_NEVER(q_no_underflow, pop && status.empty)
	`ASSERT_NEXT(q_count_up, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

[src/gng_back.sv]
// back end: log, sqrt and cordic sequencer with output register
module gng_back import gng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  uni_pair_t   head,
	input  q_status_t   q_status,
	output logic        pop,
	output logic        sample_valid,
	input  logic        sample_stall,
	output logic [15:0] sample
);

	`include "assert_macros.svh"

	localparam int RoundShift = 28 - FRACTION_BITS;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_NORM   = 9'b000000010,
		ST_LOG    = 9'b000000100,
		ST_MUL_LO = 9'b000001000,
		ST_MUL_HI = 9'b000010000,
		ST_SQRT   = 9'b000100000,
		ST_GAIN   = 9'b001000000,
		ST_ROT    = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [4:0]         cnt_q;
	logic [30:0]        x_q;
	logic [4:0]         p_q;
	logic [29:0]        f_q;
	logic [63:0]        acc_q;
	logic [63:0]        rem_q, res_q, bit_q;
	logic [31:0]        phase_q;
	logic               neg_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [15:0]        sample_q;
	logic               out_valid_q;

	logic [61:0]        sq;
	logic [31:0]        sq_sh;
	logic [34:0]        n_val;
	logic [46:0]        prod_lo;
	logic [45:0]        prod_hi;
	logic [63:0]        acc_sum;
	logic [63:0]        trial;
	logic [61:0]        gain_prod;
	logic signed [33:0] sx, sy, atan_s;
	logic signed [33:0] xn, xr;
	logic [15:0]        sat;
	logic [31:0]        phase_in;
	logic               neg_in;

	assign pop          = (state_q == ST_IDLE) && !q_status.empty;
	assign sample_valid = out_valid_q;
	assign sample       = sample_q;

	assign sq      = {31'b0, x_q} * {31'b0, x_q};
	assign sq_sh   = sq[61:30];
	assign n_val   = {5'(UNIFORM_BITS) - p_q, 30'b0} - {5'b0, f_q};
	assign prod_lo = {29'b0, n_val[17:0]} * {18'b0, TWO_LN2_Q28};
	assign prod_hi = {29'b0, n_val[34:18]} * {17'b0, TWO_LN2_Q28};
	assign acc_sum = acc_q + (64'(prod_hi) << 18);
	assign trial   = res_q + bit_q;
	assign gain_prod = {30'b0, res_q[31:0]} * {32'b0, INV_GAIN_Q30};
	assign sx      = cx_q >>> cnt_q;
	assign sy      = cy_q >>> cnt_q;
	assign atan_s  = signed'({4'b0, turn_atan(cnt_q)});

	// phase in turns, folded into the right half plane
	assign phase_in = 32'(head.v) << (32 - UNIFORM_BITS);
	assign neg_in   = phase_in[31] ^ phase_in[30];

	// round half up, then saturate
	assign xn = neg_q ? -cx_q : cx_q;
	assign xr = (xn + (34'sd1 <<< (RoundShift - 1))) >>> RoundShift;
	always_comb begin
		if (xr > 34'sd32767) begin
			sat = 16'h7fff;
		end else if (xr < -34'sd32768) begin
			sat = 16'h8000;
		end else begin
			sat = xr[15:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q     <= 31'(head.m) << (31 - UNIFORM_BITS);
				p_q     <= 5'(UNIFORM_BITS - 1);
				f_q     <= '0;
				neg_q   <= neg_in;
				phase_q <= neg_in ? (phase_in ^ 32'h80000000) : phase_in;
				rem_q   <= 64'(ZERO_U1_R2_Q30) << 26;
				res_q   <= '0;
				bit_q   <= 64'd1 << 62;
			end
			ST_NORM: begin
				if (!x_q[30]) begin
					x_q <= x_q << 1;
					p_q <= p_q - 1'b1;
				end
			end
			ST_LOG: begin
				if (sq_sh[31]) begin
					x_q                 <= sq_sh[31:1];
					f_q[5'd29 - cnt_q]  <= 1'b1;
				end else begin
					x_q <= sq_sh[30:0];
				end
			end
			ST_MUL_LO: begin
				acc_q <= 64'(prod_lo);
			end
			ST_MUL_HI: begin
				rem_q <= {2'b0, acc_sum[63:28], 26'b0};
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			ST_SQRT: begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_GAIN: begin
				cx_q <= signed'({2'b0, gain_prod[61:30]});
				cy_q <= '0;
				cz_q <= signed'({{2{phase_q[31]}}, phase_q});
			end
			ST_ROT: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					cz_q <= cz_q - atan_s;
				end else begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					cz_q <= cz_q + atan_s;
				end
			end
			ST_DONE: begin
				// a stalled sample beat keeps its value
				if (!out_valid_q || !sample_stall) begin
					sample_q <= sat;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || !sample_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !sample_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (pop) begin
						state_q <= (head.m == '0) ? ST_SQRT : ST_NORM;
					end
				end
				ST_NORM: begin
					if (x_q[30]) begin
						state_q <= ST_LOG;
					end
				end
				ST_LOG: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd29) begin
						state_q <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: begin
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					cnt_q   <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !sample_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(back_norm_bounded, state_q == ST_NORM && p_q == '0 && !x_q[30])
	`ASSERT_NEXT(back_sqrt_to_gain, state_q == ST_SQRT && cnt_q == 5'd31, state_q == ST_GAIN)
	`ASSERT_NEXT(back_out_hold, sample_valid && sample_stall, sample_valid && $stable(sample))

endmodule

[src/gaussian_noise_generator_top.sv]
// top level of the gaussian noise generator
//
// channel   dir  handshake                   payload
// draw      in   draw_valid / draw_stall     draw (1 bit, 1 asks for a sample)
// sample    out  sample_valid / sample_stall sample (16 bit signed, 12 fraction bits)
// seed cfg  in   seed_we                     seed_data (32 bit)
//
// idle draw beats give no result
// a sample is formed by the bit-serial normalize, log (30 squarings), sqrt
// (32 steps) and 28 cordic steps; a zero u1 skips normalize, log and multiply
// front and back are parted by a two-entry queue, so draws are taken while
// the back is busy or the output waits; draw_stall rises when the queue is full
// reset loads the generator with 0x12345678 and empties queue and output
module gaussian_noise_generator_top import gng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed_data,
	input  logic        draw_valid,
	output logic        draw_stall,
	input  logic        draw,
	output logic        sample_valid,
	input  logic        sample_stall,
	output logic [15:0] sample
);

	// front to queue
	logic      push;
	uni_pair_t push_pair;

	// queue to back
	logic      pop;
	uni_pair_t head;
	q_status_t q_status;

	// generator and draw acceptance
	gng_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_data  (seed_data),
		.draw_valid (draw_valid),
		.draw_stall (draw_stall),
		.draw       (draw),
		.q_status   (q_status),
		.push       (push),
		.push_pair  (push_pair)
	);

	// decoupling queue of uniform pairs
	gng_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pair (push_pair),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// box-muller math and output register
	gng_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample)
	);

endmodule

[tb/tb_gaussian_noise_generator_top.sv]
// testbench for the gaussian noise generator: predicted samples checked beat by beat
`timescale 1ns / 100ps

module tb_gaussian_noise_generator_top;
	import gng_pkg::*;

	// holds the predicted sample stream and a model of the generator word
	class noise_scoreboard;
		logic [31:0] gen_word;
		logic [15:0] expected_samples[$];
		int errors;

		function new();
			gen_word = SEED_DEFAULT;
			errors = 0;
		endfunction

		function void load_seed(logic [31:0] s);
			gen_word = (s != 0) ? s : SEED_DEFAULT;
		endfunction

		function logic [31:0] step_word();
			logic [31:0] x;
			x = gen_word;
			x ^= x << 13;
			x ^= x >> 17;
			x ^= x << 5;
			gen_word = x;
			return x;
		endfunction

		function longint unsigned minus_two_ln(longint unsigned m);
			int p;
			longint unsigned x, f, n;
			p = 31;
			f = 0;
			while (p > 0 && m[p] == 1'b0)
				p--;
			x = m << (30 - p);
			for (int i = 0; i < 30; i++) begin
				x = (x * x) >> 30;
				if (x >= (64'd1 << 31)) begin
					x >>= 1;
					f |= 64'd1 << (29 - i);
				end
			end
			n = (longint'(UNIFORM_BITS - p) << 30) - f;
			return (n * TWO_LN2_Q28) >> 28;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, bit_pos;
			res = 0;
			bit_pos = 64'd1 << 62;
			while (bit_pos > v)
				bit_pos >>= 2;
			while (bit_pos != 0) begin
				if (v >= res + bit_pos) begin
					v -= res + bit_pos;
					res = (res >> 1) + bit_pos;
				end else begin
					res >>= 1;
				end
				bit_pos >>= 2;
			end
			return res;
		endfunction

		function logic [15:0] gauss_fixed();
			longint unsigned m, v, r2;
			longint radius, x, y, z, nx, atn;
			logic [31:0] phase;
			bit negate;
			m = step_word() & 32'hFFFFFF;
			v = step_word() & 32'hFFFFFF;
			r2 = (m == 0) ? ZERO_U1_R2_Q30 : minus_two_ln(m);
			radius = longint'(int_sqrt(r2 << 26));
			phase = 32'(v << (32 - UNIFORM_BITS));
			negate = 0;
			if (((phase + 32'h40000000) & 32'h80000000) != 0) begin
				phase ^= 32'h80000000;
				negate = 1;
			end
			z = longint'(signed'(phase));
			x = (radius * longint'(INV_GAIN_Q30)) >>> 30;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				atn = longint'(turn_atan(5'(i)));
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= atn;
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += atn;
				end
				x = nx;
			end
			if (negate)
				x = -x;
			x = (x + (64'sd1 << (27 - FRACTION_BITS))) >>> (28 - FRACTION_BITS);
			if (x > 32767)
				x = 32767;
			if (x < -32768)
				x = -32768;
			return x[15:0];
		endfunction

		function void note_draw(logic d);
			if (d)
				expected_samples.push_back(gauss_fixed());
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_sample(logic [15:0] got);
			logic [15:0] want;
			if (expected_samples.size() == 0) begin
				report($sformatf("sample %h with none pending", got));
			end else begin
				want = expected_samples.pop_front();
				if (got !== want)
					report($sformatf("sample %h, predicted %h", got, want));
			end
		endtask
	endclass

	localparam int IDLE_LIMIT  = 5000;
	localparam int SETTLE_CYCS = 300;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        seed_we = 0;
	logic [31:0] seed_data = 0;
	logic        draw_valid = 0;
	logic        draw_stall;
	logic        draw = 0;
	logic        sample_valid;
	logic        sample_stall = 1;
	logic [15:0] sample;

	noise_scoreboard sb = new();
	bit calm = 0;     // no gaps on either side while set
	int idle_cycles = 0;

	gaussian_noise_generator_top uut (
		.clk(clk), .arst_n(arst_n), .seed_we(seed_we), .seed_data(seed_data),
		.draw_valid(draw_valid), .draw_stall(draw_stall), .draw(draw),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample)
	);

	always #5 clk = ~clk;

	// monitor: accepted beats feed the scoreboard, seed writes reload the model,
	// and a watchdog ends a run that stops making progress
	always @(posedge clk) begin
		if (arst_n) begin
			if (seed_we)
				sb.load_seed(seed_data);
			if (draw_valid && !draw_stall)
				sb.note_draw(draw);
			if (sample_valid && !sample_stall)
				sb.check_sample(sample);
			if ((draw_valid && !draw_stall) || (sample_valid && !sample_stall) || seed_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// receiver: random stall before each sample beat, none while calm
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			k = calm ? 0 : $urandom_range(0, 8);
			if (k > 0) begin
				sample_stall = 1;
				repeat (k) @(negedge clk);
			end
			sample_stall = 0;
			do @(posedge clk); while (!(sample_valid && !sample_stall));
		end
	end

	// one draw beat: random gap with valid low, then hold until accepted
	task send_draw(logic d);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			draw_valid = 0;
			repeat (gap) @(negedge clk);
		end
		draw_valid = 1;
		draw = d;
		do @(posedge clk); while (!(draw_valid && !draw_stall));
		@(negedge clk);
	endtask

	// wait for every pending sample, then let the back end settle
	task drain();
		draw_valid = 0;
		while (sb.expected_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCS) @(negedge clk);
	endtask

	task write_seed(logic [31:0] s);
		seed_we = 1;
		seed_data = s;
		@(negedge clk);
		seed_we = 0;
		seed_data = $urandom;
	endtask

	// seed whose first generator word is w, by undoing the three xorshift steps
	function logic [31:0] seed_for_word(logic [31:0] w);
		logic [31:0] x;
		x = w;
		repeat (7) x = w ^ (x << 5);
		w = x;
		repeat (2) x = w ^ (x >> 17);
		w = x;
		repeat (3) x = w ^ (x << 13);
		return x;
	endfunction

	task random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				calm = ($urandom_range(0, 3) == 0);
			send_draw($urandom_range(0, 9) < 8);
		end
		calm = 0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset seed, idle ticks mixed in, back-to-back draws
		send_draw(1);
		send_draw(0);
		send_draw(1);
		send_draw(0);
		send_draw(0);
		calm = 1;
		repeat (6) send_draw(1);
		calm = 0;
		// sender holds off until every sample is back
		drain();

		// zero seed falls back to the default word
		write_seed(32'h0);
		repeat (3) send_draw(1);
		drain();

		// first word with zero low bits gives a zero u1
		write_seed(seed_for_word(32'hAB000000));
		send_draw(1);
		send_draw(1);
		drain();
		write_seed(seed_for_word(32'h00000000 | 32'h01000000));
		send_draw(0);
		send_draw(1);
		drain();

		write_seed(32'hFFFFFFFF);
		random_phase(150);
		drain();

		write_seed(32'h00000001);
		random_phase(150);
		drain();

		write_seed($urandom);
		random_phase(150);
		drain();

		write_seed($urandom);
		random_phase(130);
		drain();

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
